// ===== src/cmi_pkg.sv =====
package cmi_pkg;

  localparam int CMI_DEPTH     = 256;
  localparam int ADDR_BITS     = $clog2(CMI_DEPTH);
  localparam int SIZE_BITS     = ADDR_BITS + 1;
  localparam int SAMPLE_BITS   = 32;
  localparam int VAL_BITS      = SAMPLE_BITS + 1;
  localparam int CH_BITS       = 16;
  localparam int FRAC_BITS     = 16;
  localparam int T_BITS        = VAL_BITS + ADDR_BITS;
  localparam int ACC_BITS      = CH_BITS + FRAC_BITS + 1;
  localparam int CFG_DATA_BITS = (SAMPLE_BITS > SIZE_BITS) ? SAMPLE_BITS : SIZE_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int FUNC_BITS     = 2;
  localparam int DIV_STEPS     = ADDR_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SCAN  = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_MAP   = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_USE_GIVEN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GIVEN_MIN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GIVEN_MAX = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAG_MODE  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_SIZE  = 3'd4;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } entry_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] k;
    logic [FRAC_BITS:0]   frac;
  } div_res_t;

endpackage

// ===== src/cmi_table.sv =====
module cmi_table (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [cmi_pkg::ADDR_BITS-1:0] waddr_i,
  input  cmi_pkg::entry_t          wdata_i,
  input  logic [cmi_pkg::ADDR_BITS-1:0] raddr_i,
  output cmi_pkg::entry_t          rdata_o
);
  import cmi_pkg::*;

  entry_t mem_q [CMI_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cmi_divider.sv =====
module cmi_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cmi_pkg::T_BITS-1:0]    t_i,
  input  logic [cmi_pkg::VAL_BITS-1:0]  d_i,
  input  logic [cmi_pkg::ADDR_BITS-1:0] nm1_i,
  output logic                          done_o,
  output cmi_pkg::div_res_t             res_o
);
  import cmi_pkg::*;

  localparam logic [DIV_CNT_BITS-1:0] INT_LAST  = DIV_CNT_BITS'(ADDR_BITS - 1);
  localparam logic [DIV_CNT_BITS-1:0] FRAC_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

  logic                    run_q;
  logic                    done_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [T_BITS-1:0]       rem_q;
  logic [T_BITS-1:0]       dsh_q;
  logic [ADDR_BITS-1:0]    quo_q;
  logic [FRAC_BITS:0]      frac_q;
  logic [ADDR_BITS-1:0]    nm1_q;

  logic                    int_phase;
  logic [T_BITS-1:0]       opa;
  logic [T_BITS:0]         diff;
  logic                    ge;
  logic [ADDR_BITS-1:0]    quo_n;

  // one compare-subtract per cycle: quotient bits first, then fraction bits
  assign int_phase = (cnt_q <= INT_LAST);
  assign opa       = int_phase ? rem_q : {rem_q[T_BITS-2:0], 1'b0};
  assign diff      = {1'b0, opa} - {1'b0, dsh_q};
  assign ge        = ~diff[T_BITS];
  assign quo_n     = {quo_q[ADDR_BITS-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if ((cnt_q == INT_LAST && quo_n == nm1_q) || cnt_q == FRAC_LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= t_i;
      dsh_q  <= T_BITS'(d_i) << (ADDR_BITS - 1);
      quo_q  <= '0;
      frac_q <= '0;
      nm1_q  <= nm1_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[T_BITS-1:0] : opa;
      if (int_phase) begin
        if (cnt_q != INT_LAST) begin
          dsh_q <= dsh_q >> 1;
        end
        // sample at the top of the range: clamp to the last segment, full fraction
        if (cnt_q == INT_LAST && quo_n == nm1_q) begin
          quo_q  <= nm1_q - 1'b1;
          frac_q <= FRAC_ONE;
        end else begin
          quo_q <= quo_n;
        end
      end else begin
        frac_q <= {frac_q[FRAC_BITS-1:0], ge};
      end
    end
  end

  assign done_o     = done_q;
  assign res_o.k    = quo_q;
  assign res_o.frac = frac_q;

  a_done_k_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.k < nm1_q))
    else $error("segment index past last segment");

  a_done_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.frac <= FRAC_ONE))
    else $error("fraction above one");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !run_q)
    else $error("divider still running at done");

endmodule

// ===== src/colormap_interpolator_top.sv =====
// Colormap interpolator. Items with func 0 write one colormap entry, items with
// func 1 update the tracked minimum and maximum; neither gives a result. A func 2
// item maps its sample to a color and gives one result. It runs through the
// compare-subtract divider, which yields one bit a cycle (8 index bits, then 16
// fraction bits), then two table reads and six passes of one 16x17 multiplier
// for the blend. A sample at the top of the range skips the fraction bits. An
// empty range (max not above min) skips the divide and the blend. A result still
// waiting at the output adds its wait to the next map. The input stays not ready
// while a map item is in flight. The colormap memory is not cleared at reset:
// read only entries that were written.
module colormap_interpolator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cmi_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [cmi_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cmi_pkg::FUNC_BITS-1:0]    func_i,
  input  logic                             frame_start_i,
  input  logic signed [cmi_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [cmi_pkg::ADDR_BITS-1:0]    entry_index_i,
  input  logic [cmi_pkg::CH_BITS-1:0]      red_in_i,
  input  logic [cmi_pkg::CH_BITS-1:0]      green_in_i,
  input  logic [cmi_pkg::CH_BITS-1:0]      blue_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cmi_pkg::CH_BITS-1:0]      red_o,
  output logic [cmi_pkg::CH_BITS-1:0]      green_o,
  output logic [cmi_pkg::CH_BITS-1:0]      blue_o,
  output logic                             range_error_o
);
  import cmi_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_RD0   = 4'd5;
  localparam logic [3:0] S_RD1   = 4'd6;
  localparam logic [3:0] S_RD2   = 4'd7;
  localparam logic [3:0] S_MAC   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [2:0] MAC_LAST = 3'd5;
  localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [VAL_BITS-1:0] MIN_RESET = {1'b0, {SAMPLE_BITS{1'b1}}};
  localparam logic signed [VAL_BITS-1:0] MAX_RESET = {1'b1, {SAMPLE_BITS{1'b0}}};

  function automatic logic [CH_BITS-1:0] chan_sel(entry_t e, logic [1:0] c);
    logic [CH_BITS-1:0] r;
    unique case (c)
      2'd0:    r = e.red;
      2'd1:    r = e.green;
      default: r = e.blue;
    endcase
    return r;
  endfunction

  logic [3:0] state_q, state_d;

  logic                          use_given_q;
  logic signed [SAMPLE_BITS-1:0] given_min_q;
  logic signed [SAMPLE_BITS-1:0] given_max_q;
  logic                          mag_q;
  logic [SIZE_BITS-1:0]          size_q;

  logic signed [VAL_BITS-1:0] run_min_q;
  logic signed [VAL_BITS-1:0] run_max_q;

  logic signed [VAL_BITS-1:0] v_q, lo_q, hi_q;
  logic [VAL_BITS-1:0]        d_q, diff_q;
  logic [ADDR_BITS-1:0]       k_q;
  logic [FRAC_BITS:0]         frac_q;
  entry_t                     lo_ent_q, hi_ent_q, col_q;
  logic                       err_q;
  logic [ACC_BITS-1:0]        acc_q, acc_d;
  logic [2:0]                 mcnt_q;

  logic                       out_valid_q;
  entry_t                     out_col_q;
  logic                       out_err_q;

  logic                       accept;
  logic signed [VAL_BITS-1:0] v_in;
  logic [ADDR_BITS-1:0]       nm1;
  logic [T_BITS-1:0]          t_w;
  logic                       div_start, div_done;
  div_res_t                   div_res;
  entry_t                     wr_ent, rd_ent;
  logic [ADDR_BITS-1:0]       raddr;
  logic [1:0]                 ch;
  logic                       term;
  logic [CH_BITS-1:0]         mul_a;
  logic [FRAC_BITS:0]         mul_b;
  logic [ACC_BITS-1:0]        prod;
  logic                       out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // sample as a 33-bit value, magnitude when asked
  always_comb begin
    v_in = {sample_i[SAMPLE_BITS-1], sample_i};
    if (mag_q && v_in < 0) begin
      v_in = -v_in;
    end
  end

  always_comb begin
    if (size_q < SIZE_BITS'(2)) begin
      nm1 = ADDR_BITS'(1);
    end else if (size_q > SIZE_BITS'(CMI_DEPTH)) begin
      nm1 = ADDR_BITS'(CMI_DEPTH - 1);
    end else begin
      nm1 = ADDR_BITS'(size_q - 1'b1);
    end
  end

  assign t_w       = T_BITS'(nm1) * T_BITS'(diff_q);
  assign div_start = (state_q == S_MUL);

  cmi_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .t_i     (t_w),
    .d_i     (d_q),
    .nm1_i   (nm1),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign wr_ent = '{red: red_in_i, green: green_in_i, blue: blue_in_i};
  assign raddr  = (state_q == S_RD1) ? k_q + 1'b1 : k_q;

  cmi_table u_table (
    .clk_i   (clk_i),
    .we_i    (accept && func_i == FUNC_WRITE),
    .waddr_i (entry_index_i),
    .wdata_i (wr_ent),
    .raddr_i (raddr),
    .rdata_o (rd_ent)
  );

  // blend: one product a cycle, two per channel
  assign ch    = mcnt_q[2:1];
  assign term  = mcnt_q[0];
  assign mul_a = term ? chan_sel(hi_ent_q, ch) : chan_sel(lo_ent_q, ch);
  assign mul_b = term ? frac_q : FRAC_ONE - frac_q;
  assign prod  = ACC_BITS'(mul_a) * ACC_BITS'(mul_b);
  assign acc_d = term ? acc_q + prod : prod + HALF;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && func_i == FUNC_MAP) state_d = S_SETUP;
      S_SETUP: state_d = (hi_q > lo_q) ? S_DIFF : S_OUT;
      S_DIFF:  state_d = S_MUL;
      S_MUL:   state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_RD0;
      S_RD0:   state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_MAC;
      S_MAC:   if (mcnt_q == MAC_LAST) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      use_given_q <= 1'b0;
      given_min_q <= '0;
      given_max_q <= SAMPLE_BITS'(1);
      mag_q       <= 1'b0;
      size_q      <= SIZE_BITS'(2);
      run_min_q   <= MIN_RESET;
      run_max_q   <= MAX_RESET;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_USE_GIVEN: use_given_q <= cfg_data_i[0];
          CFG_GIVEN_MIN: given_min_q <= cfg_data_i[SAMPLE_BITS-1:0];
          CFG_GIVEN_MAX: given_max_q <= cfg_data_i[SAMPLE_BITS-1:0];
          CFG_MAG_MODE:  mag_q       <= cfg_data_i[0];
          CFG_MAP_SIZE:  size_q      <= cfg_data_i[SIZE_BITS-1:0];
          default: ;
        endcase
      end
      if (accept && func_i == FUNC_SCAN) begin
        if (frame_start_i) begin
          run_min_q <= v_in;
          run_max_q <= v_in;
        end else begin
          if (v_in < run_min_q) run_min_q <= v_in;
          if (v_in > run_max_q) run_max_q <= v_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        v_q  <= v_in;
        lo_q <= use_given_q ? {given_min_q[SAMPLE_BITS-1], given_min_q} : run_min_q;
        hi_q <= use_given_q ? {given_max_q[SAMPLE_BITS-1], given_max_q} : run_max_q;
      end
      S_SETUP: begin
        err_q <= !(hi_q > lo_q);
        col_q <= '0;
        d_q   <= hi_q - lo_q;
        if (v_q < lo_q) begin
          v_q <= lo_q;
        end else if (v_q > hi_q) begin
          v_q <= hi_q;
        end
      end
      S_DIFF: diff_q <= v_q - lo_q;
      S_DIV: begin
        k_q    <= div_res.k;
        frac_q <= div_res.frac;
      end
      S_RD1: lo_ent_q <= rd_ent;
      S_RD2: begin
        hi_ent_q <= rd_ent;
        mcnt_q   <= '0;
      end
      S_MAC: begin
        acc_q  <= acc_d;
        mcnt_q <= mcnt_q + 1'b1;
        if (term) begin
          unique case (ch)
            2'd0:    col_q.red   <= acc_d[FRAC_BITS +: CH_BITS];
            2'd1:    col_q.green <= acc_d[FRAC_BITS +: CH_BITS];
            default: col_q.blue  <= acc_d[FRAC_BITS +: CH_BITS];
          endcase
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_col_q <= col_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = out_col_q.red;
  assign green_o       = out_col_q.green;
  assign blue_o        = out_col_q.blue;
  assign range_error_o = out_err_q;

  a_map_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_MAP) |=> (state_q == S_SETUP))
    else $error("map request did not start");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

  a_err_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("range error with nonzero color");

  a_no_scan_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> ($stable(run_min_q) && $stable(run_max_q)))
    else $error("tracked range changed during a map");

endmodule

// ===== tb/sv/colormap_interpolator_checker.sv =====
module colormap_interpolator_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cmi_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [cmi_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [cmi_pkg::FUNC_BITS-1:0]      func_i,
  input  logic                               frame_start_i,
  input  logic [cmi_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [cmi_pkg::ADDR_BITS-1:0]      entry_index_i,
  input  logic [cmi_pkg::CH_BITS-1:0]        red_in_i,
  input  logic [cmi_pkg::CH_BITS-1:0]        green_in_i,
  input  logic [cmi_pkg::CH_BITS-1:0]        blue_in_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [cmi_pkg::CH_BITS-1:0]        red_i,
  input  logic [cmi_pkg::CH_BITS-1:0]        green_i,
  input  logic [cmi_pkg::CH_BITS-1:0]        blue_i,
  input  logic                               range_error_i,
  output int                                 pending_o,
  output int                                 fail_count_o,
  output int                                 compared_o
);
  import cmi_pkg::*;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic               range_error;
  } pixel_t;

  localparam longint UNIT = longint'(FRAC_ONE);

  entry_t               lut [CMI_DEPTH];
  longint               scan_lo;
  longint               scan_hi;
  longint               given_lo;
  longint               given_hi;
  logic                 use_given;
  logic                 magnitude;
  logic [SIZE_BITS-1:0] size_reg;
  pixel_t               expected_pixels [$];
  int                   fails = 0;
  int                   compared = 0;

  function automatic longint sample_value(logic [SAMPLE_BITS-1:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (magnitude && v < 0) v = -v;
    return v;
  endfunction

  function automatic logic [CH_BITS-1:0] blend_channel(logic [CH_BITS-1:0] a,
                                                       logic [CH_BITS-1:0] b, longint f);
    longint acc;
    acc = longint'(a) * (UNIT - f) + longint'(b) * f + UNIT / 2;
    return CH_BITS'(acc / UNIT);
  endfunction

  function automatic pixel_t predict_pixel(logic [SAMPLE_BITS-1:0] raw);
    pixel_t px;
    longint lo, hi, v, n, d, t, k, r, f;
    lo = use_given ? given_lo : scan_lo;
    hi = use_given ? given_hi : scan_hi;
    n  = longint'(size_reg);
    if (n < 2) n = 2;
    if (n > CMI_DEPTH) n = CMI_DEPTH;
    px = '0;
    if (hi <= lo) begin
      px.range_error = 1'b1;
      return px;
    end
    v = sample_value(raw);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    d = hi - lo;
    t = (n - 1) * (v - lo);
    k = t / d;
    if (k > n - 2) k = n - 2;
    r = t - k * d;
    f = (r >= d) ? UNIT : (r * UNIT) / d;
    px.red   = blend_channel(lut[k].red,   lut[k + 1].red,   f);
    px.green = blend_channel(lut[k].green, lut[k + 1].green, f);
    px.blue  = blend_channel(lut[k].blue,  lut[k + 1].blue,  f);
    return px;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    longint v;
    if (!rst_ni) begin
      scan_lo   = 64'sd4294967295;
      scan_hi   = -64'sd4294967296;
      use_given = 1'b0;
      given_lo  = 0;
      given_hi  = 1;
      magnitude = 1'b0;
      size_reg  = SIZE_BITS'(2);
      expected_pixels.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
      compared_o   <= compared;
    end else begin
      // results leave before a request taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %h %h %b", $time,
                   red_i, green_i, blue_i, range_error_i);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, red_i);
          check_field("green", want.green, green_i);
          check_field("blue", want.blue, blue_i);
          check_field("range_error", want.range_error, range_error_i);
          compared++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (func_i)
          FUNC_WRITE: lut[entry_index_i] = '{red_in_i, green_in_i, blue_in_i};
          FUNC_SCAN: begin
            v = sample_value(sample_i);
            if (frame_start_i) begin
              scan_lo = v;
              scan_hi = v;
            end else begin
              if (v < scan_lo) scan_lo = v;
              if (v > scan_hi) scan_hi = v;
            end
          end
          FUNC_MAP: expected_pixels.push_back(predict_pixel(sample_i));
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_USE_GIVEN: use_given = cfg_data_i[0];
          CFG_GIVEN_MIN: given_lo = longint'($signed(cfg_data_i[SAMPLE_BITS-1:0]));
          CFG_GIVEN_MAX: given_hi = longint'($signed(cfg_data_i[SAMPLE_BITS-1:0]));
          CFG_MAG_MODE:  magnitude = cfg_data_i[0];
          CFG_MAP_SIZE:  size_reg = cfg_data_i[SIZE_BITS-1:0];
          default: ;
        endcase
      end
      pending_o    <= expected_pixels.size();
      fail_count_o <= fails;
      compared_o   <= compared;
    end
  end

endmodule

// ===== tb/sv/colormap_interpolator_top_test.sv =====
module colormap_interpolator_top_test;
  import cmi_pkg::*;

  localparam logic [FUNC_BITS-1:0] FUNC_IDLE = 2'd3;
  localparam int TARGET_ITEMS  = 1550;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_GAP       = 17;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [FUNC_BITS-1:0]     func = FUNC_WRITE;
  logic                     frame_start = 1'b0;
  logic [SAMPLE_BITS-1:0]   sample = '0;
  logic [ADDR_BITS-1:0]     entry_index = '0;
  logic [CH_BITS-1:0]       red_in = '0;
  logic [CH_BITS-1:0]       green_in = '0;
  logic [CH_BITS-1:0]       blue_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CH_BITS-1:0]       red;
  logic [CH_BITS-1:0]       green;
  logic [CH_BITS-1:0]       blue;
  logic                     range_error;

  int pending;
  int fail_count;
  int n_compared;

  bit                   lut_written [CMI_DEPTH];
  logic [SIZE_BITS-1:0] size_setting = SIZE_BITS'(2);
  bit                   cur_use_given = 1'b0;
  logic [31:0]          cur_lo = 32'd0;
  logic [31:0]          cur_hi = 32'd1;
  logic [31:0]          frame_samples [$];
  bit                   tx_calm = 1'b0;
  bit                   rx_calm = 1'b0;
  int                   rx_wait = 0;
  int                   cycles = 0;
  int n_requests = 0, n_writes = 0, n_scans = 0, n_maps = 0, n_ignored = 0, n_settings = 0;

  colormap_interpolator_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .frame_start_i (frame_start),
    .sample_i      (sample),
    .entry_index_i (entry_index),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .range_error_o (range_error)
  );

  colormap_interpolator_checker color_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (func),
    .frame_start_i (frame_start),
    .sample_i      (sample),
    .entry_index_i (entry_index),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .range_error_i (range_error),
    .pending_o     (pending),
    .fail_count_o  (fail_count),
    .compared_o    (n_compared)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("colormap_interpolator_top_test NOT OK");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk or negedge rst_n) begin
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (out_ready && out_valid) begin
      gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_ready <= 1'b0;
        rx_wait   <= gap - 1;
      end
    end else if (!out_ready) begin
      if (rx_wait == 0) out_ready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  function automatic logic [CH_BITS-1:0] rand_channel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CH_BITS'($urandom);
    endcase
  endfunction

  function automatic entry_t rand_color();
    return '{rand_channel(), rand_channel(), rand_channel()};
  endfunction

  function automatic int active_entries();
    if (size_setting < 2) return 2;
    if (size_setting > CMI_DEPTH) return CMI_DEPTH;
    return int'(size_setting);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [31:0] center,
                                                         logic [31:0] spread);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      3, 4: begin
        if (cur_use_given) return $urandom_range(0, 1) ? cur_lo : cur_hi;
        if (frame_samples.size() != 0)
          return frame_samples[$urandom_range(0, frame_samples.size() - 1)];
        return center;
      end
      default: return center + ($urandom % (spread + 1)) - (spread >> 1);
    endcase
  endfunction

  task automatic send_request(logic [FUNC_BITS-1:0] f, logic fs, logic [SAMPLE_BITS-1:0] smp,
                              logic [ADDR_BITS-1:0] idx, entry_t col);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    frame_start <= fs;
    sample      <= smp;
    entry_index <= idx;
    red_in      <= col.red;
    green_in    <= col.green;
    blue_in     <= col.blue;
    do @(posedge clk); while (!in_ready);
    n_requests++;
    case (f)
      FUNC_WRITE: begin
        n_writes++;
        lut_written[idx] = 1'b1;
      end
      FUNC_SCAN: n_scans++;
      FUNC_MAP:  n_maps++;
      default:   n_ignored++;
    endcase
  endtask

  task automatic write_entry(logic [ADDR_BITS-1:0] idx, entry_t col);
    send_request(FUNC_WRITE, 1'($urandom), $urandom, idx, col);
  endtask

  task automatic scan_sample(logic fs, logic [SAMPLE_BITS-1:0] smp);
    send_request(FUNC_SCAN, fs, smp, ADDR_BITS'($urandom), rand_color());
  endtask

  task automatic map_sample(logic [SAMPLE_BITS-1:0] smp);
    send_request(FUNC_MAP, 1'($urandom), smp, ADDR_BITS'($urandom), rand_color());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_block(bit use_given, logic [31:0] lo, logic [31:0] hi, bit mag,
                               logic [SIZE_BITS-1:0] size);
    wait_idle();
    write_reg(CFG_USE_GIVEN, CFG_DATA_BITS'(use_given));
    write_reg(CFG_GIVEN_MIN, CFG_DATA_BITS'(lo));
    write_reg(CFG_GIVEN_MAX, CFG_DATA_BITS'(hi));
    write_reg(CFG_MAG_MODE, CFG_DATA_BITS'(mag));
    write_reg(CFG_MAP_SIZE, CFG_DATA_BITS'(size));
    cfg_we        <= 1'b0;
    size_setting  = size;
    cur_use_given = use_given;
    cur_lo        = lo;
    cur_hi        = hi;
    n_settings++;
  endtask

  // every entry a map can reach must hold a color
  task automatic fill_table();
    for (int i = 0; i < active_entries(); i++)
      if (!lut_written[i]) write_entry(ADDR_BITS'(i), rand_color());
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_request(FUNC_IDLE, 1'($urandom), $urandom, ADDR_BITS'($urandom), rand_color());
      1: write_entry(ADDR_BITS'($urandom), rand_color());
      default: scan_sample(1'b0, $urandom);
    endcase
  endtask

  task automatic run_phase();
    logic [31:0]          lo, hi, center, spread, smp;
    logic [SIZE_BITS-1:0] size;
    bit                   ug;
    int                   len;
    ug = $urandom_range(0, 1);
    case ($urandom_range(0, 4))
      0: begin lo = $urandom; hi = $urandom; end
      1: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
      2: begin lo = $urandom; hi = lo; end
      default: begin lo = $urandom; hi = lo + $urandom_range(1, 5000); end
    endcase
    case ($urandom_range(0, 11))
      0: size = SIZE_BITS'(256);
      1: size = SIZE_BITS'(2);
      2: size = SIZE_BITS'($urandom_range(0, 1));
      3: size = SIZE_BITS'($urandom_range(257, 511));
      4: size = SIZE_BITS'($urandom_range(17, 255));
      default: size = SIZE_BITS'($urandom_range(2, 16));
    endcase
    program_block(ug, lo, hi, $urandom_range(0, 1), size);
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    fill_table();
    repeat ($urandom_range(2, 4)) begin
      center = ug ? lo + ((hi - lo) >> 1) : $urandom;
      case ($urandom_range(0, 3))
        0: spread = 32'd0;
        1: spread = 32'd64;
        2: spread = 32'h0010_0000;
        default: spread = 32'h7fff_ffff;
      endcase
      frame_samples.delete();
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        smp = pick_sample(center, spread);
        frame_samples.push_back(smp);
        scan_sample(i == 0 && $urandom_range(0, 9) != 0, smp);
      end
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        map_sample(pick_sample(center, spread));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tracked range still at reset: empty
    map_sample(32'd0);
    send_request(FUNC_IDLE, 1'b1, $urandom, ADDR_BITS'($urandom), rand_color());
    write_entry(ADDR_BITS'(0), '0);
    write_entry(ADDR_BITS'(1), '1);
    scan_sample(1'b1, 32'h8000_0000);
    scan_sample(1'b0, 32'h7fff_ffff);
    map_sample(32'h8000_0000);
    map_sample(32'h7fff_ffff);
    map_sample(32'd0);
    map_sample(32'd1);
    // single-sample frame
    scan_sample(1'b1, 32'd5);
    map_sample(32'd5);
    // size below two saturates
    program_block(1'b1, 32'h8000_0000, 32'h7fff_ffff, 1'b0, SIZE_BITS'(0));
    map_sample(32'h8000_0000);
    map_sample(32'h7fff_ffff);
    program_block(1'b1, 32'd10, 32'd10, 1'b1, SIZE_BITS'(1));
    map_sample(32'hffff_fff9);
    program_block(1'b1, 32'd100, 32'hffff_ff9c, 1'b0, SIZE_BITS'(2));
    map_sample(32'd0);
    // magnitude of the most negative sample
    program_block(1'b0, 32'd0, 32'd1, 1'b1, SIZE_BITS'(3));
    write_entry(ADDR_BITS'(2), entry_t'{16'h1234, 16'hfedc, 16'h8000});
    scan_sample(1'b1, 32'h8000_0000);
    scan_sample(1'b0, 32'd0);
    map_sample(32'h8000_0000);
    map_sample(32'hffff_fffb);
    map_sample(32'h0000_3039);

    while ((n_requests - n_ignored) < TARGET_ITEMS) run_phase();
    wait_idle();

    $display("covered %0d requests: %0d entry writes, %0d scans, %0d maps, %0d ignored",
             n_requests, n_writes, n_scans, n_maps, n_ignored);
    $display("%0d colors compared over %0d register settings", n_compared, n_settings);
    if (fail_count == 0) begin
      $display("colormap_interpolator_top_test OK");
    end else begin
      $display("colormap_interpolator_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cmi_pkg.sv
src/cmi_table.sv
src/cmi_divider.sv
src/colormap_interpolator_top.sv
tb/sv/colormap_interpolator_checker.sv
tb/sv/colormap_interpolator_top_test.sv
